// ----- design/ahhcd_pkg.sv -----
// ----------------------------------------------------------------------------
// ahhcd_pkg
// shared types and constants of the half cycle detector
// ----------------------------------------------------------------------------
package ahhcd_pkg;

  // sample width used internally; the port stays 16 bits wide
  localparam int SAMPLE_BITS = 16;
  localparam int PORT_BITS   = 16;
  // working width for extreme +/- margin arithmetic (margin is 16 bits unsigned)
  localparam int CALC_W      = 18;

  localparam logic [15:0] MIN_MARGIN = 16'd40;

  typedef logic signed [PORT_BITS-1:0]   port_sample_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [CALC_W-1:0]      calc_t;
  typedef logic [31:0]                   ms_t;
  typedef logic [1:0]                    status_t;

  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // result status codes
  localparam status_t ST_PROCESSED  = 2'd0;
  localparam status_t ST_TIMEOUT    = 2'd1;
  localparam status_t ST_NOISE_DROP = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W             = 3;
  localparam int          CFG_DATA_W            = 32;
  localparam logic [2:0]  REG_NOISE_AMPLITUDE   = 3'd0;
  localparam logic [2:0]  REG_NOISE_MARGIN_Q8   = 3'd1;
  localparam logic [2:0]  REG_STATIC_MARGIN     = 3'd2;
  localparam logic [2:0]  REG_SPAN_MARGIN_Q8    = 3'd3;
  localparam logic [2:0]  REG_RESET_FRACTION_Q8 = 3'd4;
  localparam logic [2:0]  REG_NOISE_DROP_MIN    = 3'd5;
  localparam logic [2:0]  REG_QUIET_LIMIT_MS    = 3'd6;
  localparam logic [2:0]  REG_CHANGE_THRESHOLD  = 3'd7;

endpackage

// ----- design/ahhcd_in_if.sv -----
// ----------------------------------------------------------------------------
// ahhcd_in_if
// sample channel: valid/ready handshake with sample, time and window span
// ----------------------------------------------------------------------------
interface ahhcd_in_if;
  logic                       valid;
  logic                       ready;
  ahhcd_pkg::port_sample_t    sample;
  ahhcd_pkg::ms_t             now_ms;
  logic                       span_valid;
  logic [15:0]                span;

  modport source (output valid, sample, now_ms, span_valid, span, input ready);
  modport sink   (input valid, sample, now_ms, span_valid, span, output ready);
endinterface

// ----- design/ahhcd_out_if.sv -----
// ----------------------------------------------------------------------------
// ahhcd_out_if
// result channel: valid/ready handshake with detector status and thresholds
// ----------------------------------------------------------------------------
interface ahhcd_out_if;
  logic                       valid;
  logic                       ready;
  ahhcd_pkg::status_t         status;
  logic                       half_cycle;
  logic                       value_changed;
  logic                       threshold_set;
  ahhcd_pkg::port_sample_t    wake_threshold;
  ahhcd_pkg::port_sample_t    min_seen;
  ahhcd_pkg::port_sample_t    max_seen;

  modport source (output valid, status, half_cycle, value_changed, threshold_set,
                  wake_threshold, min_seen, max_seen, input ready);
  modport sink   (input valid, status, half_cycle, value_changed, threshold_set,
                  wake_threshold, min_seen, max_seen, output ready);
endinterface

// ----- design/adaptive_hysteresis_half_cycle_detector_unit.sv -----
// ----------------------------------------------------------------------------
// adaptive_hysteresis_half_cycle_detector_unit
// peak/valley tracker with adaptive hysteresis margin, timeout and noise drop
// ----------------------------------------------------------------------------
// an accepted word passes the input register, then the result register
// throughput: one word per cycle while the result sink drains; the tracker state is
//   updated in a single pass between the input register and the result register
// reset (rst_n low, synchronous): handshake state, tracker state and config
//   registers return to their defaults at once; no clearing pass is needed
module adaptive_hysteresis_half_cycle_detector_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ahhcd_in_if.sink                              in_ch,
  ahhcd_out_if.source                           out_ch,
  input  logic                                  cfg_we,
  input  logic [ahhcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ahhcd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int SB = ahhcd_pkg::SAMPLE_BITS;
  localparam int CW = ahhcd_pkg::CALC_W;

  // saturate an unsigned value to 16 bits
  function automatic logic [15:0] sat16u(input logic [24:0] v);
    logic [15:0] r;
    begin
      r = (v > 25'd65535) ? 16'hFFFF : v[15:0];
      return r;
    end
  endfunction

  // clamp a wide signed value to the sample range
  function automatic ahhcd_pkg::sample_t sat_sample(input ahhcd_pkg::calc_t v);
    ahhcd_pkg::calc_t hi;
    ahhcd_pkg::calc_t lo;
    ahhcd_pkg::sample_t r;
    begin
      hi = CW'(ahhcd_pkg::S_MAX);
      lo = CW'(ahhcd_pkg::S_MIN);
      if (v > hi) r = ahhcd_pkg::S_MAX;
      else if (v < lo) r = ahhcd_pkg::S_MIN;
      else r = v[SB-1:0];
      return r;
    end
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [11:0] noise_amp_r;
  logic [9:0]  noise_margin_q8_r;
  logic [11:0] static_margin_r;
  logic [8:0]  span_margin_q8_r;
  logic [8:0]  reset_frac_q8_r;
  logic [11:0] noise_drop_min_r;
  logic [31:0] quiet_limit_r;
  logic [11:0] change_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_amp_r       <= '0;
      noise_margin_q8_r <= '0;
      static_margin_r   <= '0;
      span_margin_q8_r  <= '0;
      reset_frac_q8_r   <= '0;
      noise_drop_min_r  <= '0;
      quiet_limit_r     <= '1;
      change_thr_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ahhcd_pkg::REG_NOISE_AMPLITUDE:   noise_amp_r       <= cfg_wdata[11:0];
        ahhcd_pkg::REG_NOISE_MARGIN_Q8:   noise_margin_q8_r <= cfg_wdata[9:0];
        ahhcd_pkg::REG_STATIC_MARGIN:     static_margin_r   <= cfg_wdata[11:0];
        ahhcd_pkg::REG_SPAN_MARGIN_Q8:    span_margin_q8_r  <= cfg_wdata[8:0];
        ahhcd_pkg::REG_RESET_FRACTION_Q8: reset_frac_q8_r   <= cfg_wdata[8:0];
        ahhcd_pkg::REG_NOISE_DROP_MIN:    noise_drop_min_r  <= cfg_wdata[11:0];
        ahhcd_pkg::REG_QUIET_LIMIT_MS:    quiet_limit_r     <= cfg_wdata;
        ahhcd_pkg::REG_CHANGE_THRESHOLD:  change_thr_r      <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake between the input register and the result register
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic in_fire;
  logic out_load;

  // result register loads whenever it is empty or being drained
  assign out_load     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || out_load;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // input stage: margin and noise-drop test need only the word and config
  // --------------------------------------------------------------------------
  logic [21:0] noise_prod;
  logic [16:0] noise_margin;
  logic [24:0] span_prod;
  logic [15:0] span_margin;
  logic [15:0] margin_in;
  logic [20:0] drop_prod;
  logic [16:0] noise_minus_span;
  logic        drop_in;

  always_comb begin
    noise_prod   = 22'(noise_amp_r) * 22'(noise_margin_q8_r);
    noise_margin = 17'(noise_amp_r) + 17'(noise_prod[21:8]) + 17'(static_margin_r);
    span_prod    = 25'(in_ch.span) * 25'(span_margin_q8_r);
    span_margin  = sat16u(25'(span_prod[24:8]));

    // largest of the floor, the noise based margin and, with a valid span, the span fraction
    margin_in = ahhcd_pkg::MIN_MARGIN;
    if (sat16u(25'(noise_margin)) > margin_in) margin_in = sat16u(25'(noise_margin));
    if (in_ch.span_valid && (span_margin > margin_in)) margin_in = span_margin;

    // noise drop: span well below noise and by more than the minimum step
    drop_prod        = 21'(noise_amp_r) * 21'(reset_frac_q8_r);
    noise_minus_span = 17'(noise_amp_r) - 17'(in_ch.span);
    drop_in = in_ch.span_valid
           && ({in_ch.span, 8'h00} < 24'(drop_prod))
           && !noise_minus_span[16]
           && (noise_minus_span[15:0] > 16'(noise_drop_min_r));
  end

  ahhcd_pkg::sample_t s1_val_r;
  ahhcd_pkg::ms_t     s1_now_r;
  logic [15:0]        s1_margin_r;
  logic               s1_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_val_r    <= in_ch.sample[SB-1:0];
      s1_now_r    <= in_ch.now_ms;
      s1_margin_r <= margin_in;
      s1_drop_r   <= drop_in;
    end
  end

  // --------------------------------------------------------------------------
  // tracker state
  // --------------------------------------------------------------------------
  logic               rising_r,  rising_nxt;
  logic               setup_r,   setup_nxt;
  ahhcd_pkg::sample_t peak_r,    peak_nxt;
  ahhcd_pkg::sample_t valley_r,  valley_nxt;
  ahhcd_pkg::sample_t lowest_r,  lowest_nxt;
  ahhcd_pkg::sample_t highest_r, highest_nxt;
  ahhcd_pkg::sample_t prev_r,    prev_nxt;
  ahhcd_pkg::ms_t     last_turn_r, last_turn_nxt;

  // result fields of the word in the input register
  ahhcd_pkg::status_t status_c;
  logic               half_c;
  logic               changed_c;
  logic               tset_c;
  ahhcd_pkg::sample_t wake_c;

  ahhcd_pkg::calc_t val_w;
  ahhcd_pkg::calc_t margin_w;
  ahhcd_pkg::calc_t peak_w;
  ahhcd_pkg::calc_t valley_w;
  ahhcd_pkg::calc_t step_w;
  ahhcd_pkg::calc_t step_abs;
  ahhcd_pkg::ms_t   quiet_ms;
  logic             timeout;
  logic             turned;

  always_comb begin
    rising_nxt    = rising_r;
    setup_nxt     = setup_r;
    peak_nxt      = peak_r;
    valley_nxt    = valley_r;
    lowest_nxt    = lowest_r;
    highest_nxt   = highest_r;
    prev_nxt      = prev_r;
    last_turn_nxt = last_turn_r;

    status_c  = ahhcd_pkg::ST_PROCESSED;
    half_c    = 1'b0;
    changed_c = 1'b0;
    tset_c    = 1'b0;
    wake_c    = '0;
    turned    = 1'b0;

    val_w    = CW'(s1_val_r);
    margin_w = signed'({2'b00, s1_margin_r});
    peak_w   = CW'(peak_r);
    valley_w = CW'(valley_r);
    step_w   = CW'(prev_r) - val_w;
    step_abs = step_w[CW-1] ? -step_w : step_w;

    // elapsed time wraps modulo 2^32
    quiet_ms = s1_now_r - last_turn_r;
    timeout  = quiet_ms > quiet_limit_r;

    if (timeout) begin
      status_c = ahhcd_pkg::ST_TIMEOUT;
    end else if (s1_drop_r) begin
      status_c = ahhcd_pkg::ST_NOISE_DROP;
    end else begin
      if (s1_val_r < lowest_r)  lowest_nxt  = s1_val_r;
      if (s1_val_r > highest_r) highest_nxt = s1_val_r;

      if (rising_r) begin
        if (val_w < peak_w - margin_w) begin
          // fell away from the peak: now tracking the valley
          turned     = 1'b1;
          peak_nxt   = ahhcd_pkg::S_MIN;
          valley_nxt = s1_val_r;
          wake_c     = sat_sample(val_w + margin_w);
          tset_c     = 1'b1;
        end else if (val_w > peak_w) begin
          peak_nxt = s1_val_r;
          wake_c   = sat_sample(val_w - margin_w);
          tset_c   = 1'b1;
        end
      end else begin
        if (val_w > valley_w + margin_w) begin
          // rose away from the valley: now tracking the peak
          turned     = 1'b1;
          valley_nxt = ahhcd_pkg::S_MAX;
          peak_nxt   = s1_val_r;
          wake_c     = sat_sample(val_w - margin_w);
          tset_c     = 1'b1;
        end else if (val_w < valley_w) begin
          valley_nxt = s1_val_r;
          wake_c     = sat_sample(val_w + margin_w);
          tset_c     = 1'b1;
        end
      end

      // the first turn only sets the direction, later ones are half cycles
      if (turned) begin
        rising_nxt = !rising_r;
        if (setup_r) begin
          setup_nxt = 1'b0;
        end else begin
          half_c        = 1'b1;
          last_turn_nxt = s1_now_r;
        end
      end

      changed_c = step_abs[CW-2:0] > (CW-1)'(change_thr_r);
      prev_nxt  = s1_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rising_r    <= 1'b1;
      setup_r     <= 1'b1;
      peak_r      <= ahhcd_pkg::S_MIN;
      valley_r    <= ahhcd_pkg::S_MAX;
      lowest_r    <= ahhcd_pkg::S_MAX;
      highest_r   <= ahhcd_pkg::S_MIN;
      prev_r      <= '0;
      last_turn_r <= '0;
    end else if (out_load) begin
      rising_r    <= rising_nxt;
      setup_r     <= setup_nxt;
      peak_r      <= peak_nxt;
      valley_r    <= valley_nxt;
      lowest_r    <= lowest_nxt;
      highest_r   <= highest_nxt;
      prev_r      <= prev_nxt;
      last_turn_r <= last_turn_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  ahhcd_pkg::status_t      out_status_r;
  logic                    out_half_r;
  logic                    out_changed_r;
  logic                    out_tset_r;
  ahhcd_pkg::port_sample_t out_wake_r;
  ahhcd_pkg::port_sample_t out_min_r;
  ahhcd_pkg::port_sample_t out_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= status_c;
      out_half_r    <= half_c;
      out_changed_r <= changed_c;
      out_tset_r    <= tset_c;
      out_wake_r    <= ahhcd_pkg::PORT_BITS'(wake_c);
      out_min_r     <= ahhcd_pkg::PORT_BITS'(lowest_nxt);
      out_max_r     <= ahhcd_pkg::PORT_BITS'(highest_nxt);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.half_cycle     = out_half_r;
  assign out_ch.value_changed  = out_changed_r;
  assign out_ch.threshold_set  = out_tset_r;
  assign out_ch.wake_threshold = out_wake_r;
  assign out_ch.min_seen       = out_min_r;
  assign out_ch.max_seen       = out_max_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the input side only stalls when both registers are full and the sink waits
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

  // a timeout or noise drop word carries no detector events
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ahhcd_pkg::ST_PROCESSED))
      |-> (!out_half_r && !out_changed_r && !out_tset_r && (out_wake_r == '0)))
    else $error("rejected word carries events");

  // a half cycle always comes with a fresh wake threshold
  a_half_sets_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_half_r) |-> out_tset_r)
    else $error("half cycle without new threshold");

  // after any processed sample the seen range is ordered
  a_seen_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ahhcd_pkg::ST_PROCESSED))
      |-> (out_min_r <= out_max_r))
    else $error("min seen above max seen");

  // a half cycle marks the turn time with the word's own timestamp
  a_turn_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && half_c) |=> (last_turn_r == $past(s1_now_r)))
    else $error("turn time not recorded");

endmodule

// ----- test/adaptive_hysteresis_half_cycle_detector_unit_test.sv -----
// ----------------------------------------------------------------------------
// adaptive_hysteresis_half_cycle_detector_unit_test
// drives sample words with random gaps against a result sink that stalls at
// random, predicts every result word from an in-bench tracker model and checks
// each one field by field; directed cases first, then waveform-shaped random
// bursts under several register settings and one long result stall
// ----------------------------------------------------------------------------
module adaptive_hysteresis_half_cycle_detector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // expected content of one result word
  typedef struct {
    ahhcd_pkg::status_t      status;
    logic                    half_cycle;
    logic                    value_changed;
    logic                    threshold_set;
    ahhcd_pkg::port_sample_t wake_threshold;
    ahhcd_pkg::port_sample_t min_seen;
    ahhcd_pkg::port_sample_t max_seen;
  } detector_word_t;

  // register settings used by the random phases
  typedef enum {SET_DEFAULT, SET_MODERATE, SET_WIDEST, SET_ZERO, SET_SCRAMBLED} setting_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ahhcd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ahhcd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ahhcd_in_if  in_ch();
  ahhcd_out_if out_ch();

  adaptive_hysteresis_half_cycle_detector_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copies, held at their field widths
  logic [11:0] noise_level;
  logic [9:0]  noise_gain_q8;
  logic [11:0] fixed_margin;
  logic [8:0]  span_gain_q8;
  logic [8:0]  drop_fraction_q8;
  logic [11:0] drop_floor;
  logic [31:0] quiet_limit;
  logic [11:0] step_threshold;

  // tracker state, reset values as the block comes out of reset
  bit   tracking_up       = 1'b1;
  bit   first_turn_pending = 1'b1;
  int   peak_level        = -32768;
  int   valley_level      = 32767;
  int   lowest_level      = 32767;
  int   highest_level     = -32768;
  int   last_sample       = 0;
  ahhcd_pkg::ms_t last_half_ms = '0;

  detector_word_t pending_results[$];
  int  mismatch_count = 0;
  bit  idling = 1'b1;     // random gaps on both sides when set
  int  hold_left = 0;     // long receiver hold-off, counted down by the sink
  int  stall_left = 0;

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp_sample(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // tracker prediction for one accepted sample word; updates the bench state
  function automatic detector_word_t track_sample(input int smp, input ahhcd_pkg::ms_t now,
                                                  input logic sv, input logic [15:0] sp);
    detector_word_t w;
    int     margin, wake, step;
    longint noise_term, span_term;
    bit     turned;
    w = '{status: ahhcd_pkg::ST_PROCESSED, half_cycle: 1'b0, value_changed: 1'b0,
          threshold_set: 1'b0, wake_threshold: '0, min_seen: '0, max_seen: '0};
    wake = 0;
    turned = 1'b0;
    if (ahhcd_pkg::ms_t'(now - last_half_ms) > quiet_limit) begin
      // too long since the last half cycle, state frozen
      w.status = ahhcd_pkg::ST_TIMEOUT;
    end else if (sv && longint'(sp) * 256 < longint'(noise_level) * longint'(drop_fraction_q8)
                 && int'(noise_level) - int'(sp) > int'(drop_floor)) begin
      // window span has collapsed well below the noise level
      w.status = ahhcd_pkg::ST_NOISE_DROP;
    end else begin
      if (smp < lowest_level) lowest_level = smp;
      if (smp > highest_level) highest_level = smp;

      // hysteresis margin: floor, noise based term, span based term
      margin = int'(ahhcd_pkg::MIN_MARGIN);
      noise_term = longint'(noise_level) +
                   ((longint'(noise_level) * longint'(noise_gain_q8)) >> 8) +
                   longint'(fixed_margin);
      if (noise_term > 65535) noise_term = 65535;
      if (noise_term > margin) margin = int'(noise_term);
      if (sv) begin
        span_term = (longint'(sp) * longint'(span_gain_q8)) >> 8;
        if (span_term > 65535) span_term = 65535;
        if (span_term > margin) margin = int'(span_term);
      end

      if (tracking_up) begin
        if (smp < peak_level - margin) begin
          turned = 1'b1;
          peak_level = -32768;
          valley_level = smp;
          wake = clamp_sample(valley_level + margin);
          w.threshold_set = 1'b1;
        end else if (smp > peak_level) begin
          peak_level = smp;
          wake = clamp_sample(peak_level - margin);
          w.threshold_set = 1'b1;
        end
      end else begin
        if (smp > valley_level + margin) begin
          turned = 1'b1;
          valley_level = 32767;
          peak_level = smp;
          wake = clamp_sample(peak_level - margin);
          w.threshold_set = 1'b1;
        end else if (smp < valley_level) begin
          valley_level = smp;
          wake = clamp_sample(valley_level + margin);
          w.threshold_set = 1'b1;
        end
      end

      // the very first turn only settles the direction
      if (turned) begin
        tracking_up = !tracking_up;
        if (first_turn_pending) begin
          first_turn_pending = 1'b0;
        end else begin
          w.half_cycle = 1'b1;
          last_half_ms = now;
        end
      end

      step = last_sample - smp;
      if (step < 0) step = -step;
      w.value_changed = (step > int'(step_threshold));
      last_sample = smp;
      w.wake_threshold = ahhcd_pkg::port_sample_t'(wake);
    end
    w.min_seen = ahhcd_pkg::port_sample_t'(lowest_level);
    w.max_seen = ahhcd_pkg::port_sample_t'(highest_level);
    return w;
  endfunction

  // one sample word; entered and left just after a falling edge
  task automatic send_sample(input int smp, input ahhcd_pkg::ms_t now, input logic sv,
                             input logic [15:0] sp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.sample     = ahhcd_pkg::port_sample_t'(smp);
    in_ch.now_ms     = now;
    in_ch.span_valid = sv;
    in_ch.span       = sp;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(track_sample(smp, now, sv, sp));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_register(input logic [ahhcd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ahhcd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      ahhcd_pkg::REG_NOISE_AMPLITUDE:   noise_level      = data[11:0];
      ahhcd_pkg::REG_NOISE_MARGIN_Q8:   noise_gain_q8    = data[9:0];
      ahhcd_pkg::REG_STATIC_MARGIN:     fixed_margin     = data[11:0];
      ahhcd_pkg::REG_SPAN_MARGIN_Q8:    span_gain_q8     = data[8:0];
      ahhcd_pkg::REG_RESET_FRACTION_Q8: drop_fraction_q8 = data[8:0];
      ahhcd_pkg::REG_NOISE_DROP_MIN:    drop_floor       = data[11:0];
      ahhcd_pkg::REG_QUIET_LIMIT_MS:    quiet_limit      = data;
      ahhcd_pkg::REG_CHANGE_THRESHOLD:  step_threshold   = data[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // wait for every outstanding result word, then for the pipeline to settle
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_setting(input setting_t which);
    drain_results();
    case (which)
      SET_DEFAULT: begin
        write_register(ahhcd_pkg::REG_NOISE_AMPLITUDE, 0);
        write_register(ahhcd_pkg::REG_NOISE_MARGIN_Q8, 0);
        write_register(ahhcd_pkg::REG_STATIC_MARGIN, 0);
        write_register(ahhcd_pkg::REG_SPAN_MARGIN_Q8, 0);
        write_register(ahhcd_pkg::REG_RESET_FRACTION_Q8, 0);
        write_register(ahhcd_pkg::REG_NOISE_DROP_MIN, 0);
        write_register(ahhcd_pkg::REG_QUIET_LIMIT_MS, 32'hFFFF_FFFF);
        write_register(ahhcd_pkg::REG_CHANGE_THRESHOLD, 0);
      end
      SET_MODERATE: begin
        write_register(ahhcd_pkg::REG_NOISE_AMPLITUDE, 300);
        write_register(ahhcd_pkg::REG_NOISE_MARGIN_Q8, 128);
        write_register(ahhcd_pkg::REG_STATIC_MARGIN, 50);
        write_register(ahhcd_pkg::REG_SPAN_MARGIN_Q8, 64);
        write_register(ahhcd_pkg::REG_RESET_FRACTION_Q8, 200);
        write_register(ahhcd_pkg::REG_NOISE_DROP_MIN, 20);
        write_register(ahhcd_pkg::REG_QUIET_LIMIT_MS, 3000);
        write_register(ahhcd_pkg::REG_CHANGE_THRESHOLD, 200);
      end
      SET_WIDEST: begin
        write_register(ahhcd_pkg::REG_NOISE_AMPLITUDE, 4095);
        write_register(ahhcd_pkg::REG_NOISE_MARGIN_Q8, 1023);
        write_register(ahhcd_pkg::REG_STATIC_MARGIN, 4095);
        write_register(ahhcd_pkg::REG_SPAN_MARGIN_Q8, 511);
        write_register(ahhcd_pkg::REG_RESET_FRACTION_Q8, 511);
        write_register(ahhcd_pkg::REG_NOISE_DROP_MIN, 4095);
        write_register(ahhcd_pkg::REG_QUIET_LIMIT_MS, 32'hFFFF_FFFF);
        write_register(ahhcd_pkg::REG_CHANGE_THRESHOLD, 4095);
      end
      SET_ZERO: begin
        write_register(ahhcd_pkg::REG_NOISE_AMPLITUDE, 0);
        write_register(ahhcd_pkg::REG_NOISE_MARGIN_Q8, 0);
        write_register(ahhcd_pkg::REG_STATIC_MARGIN, 0);
        write_register(ahhcd_pkg::REG_SPAN_MARGIN_Q8, 0);
        write_register(ahhcd_pkg::REG_RESET_FRACTION_Q8, 0);
        write_register(ahhcd_pkg::REG_NOISE_DROP_MIN, 0);
        write_register(ahhcd_pkg::REG_QUIET_LIMIT_MS, 0);
        write_register(ahhcd_pkg::REG_CHANGE_THRESHOLD, 0);
      end
      default: begin
        // full-width junk, the unused upper bits must be dropped
        write_register(ahhcd_pkg::REG_NOISE_AMPLITUDE, $urandom);
        write_register(ahhcd_pkg::REG_NOISE_MARGIN_Q8, $urandom);
        write_register(ahhcd_pkg::REG_STATIC_MARGIN, $urandom);
        write_register(ahhcd_pkg::REG_SPAN_MARGIN_Q8, $urandom);
        write_register(ahhcd_pkg::REG_RESET_FRACTION_Q8, $urandom);
        write_register(ahhcd_pkg::REG_NOISE_DROP_MIN, $urandom);
        write_register(ahhcd_pkg::REG_QUIET_LIMIT_MS, $urandom);
        write_register(ahhcd_pkg::REG_CHANGE_THRESHOLD, $urandom);
      end
    endcase
  endtask

  // bursts of noisy triangle waves, so that peaks and valleys really turn,
  // mixed with fully random words
  task automatic run_waveform(input int count);
    int   sent, k, burst_len, half, pos, tri_pos, centre, amp, jitter, val, r, span_w;
    ahhcd_pkg::ms_t ofs;
    logic sv;
    logic [15:0] sp;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_sample(int'($signed(16'($urandom))), $urandom, 1'($urandom_range(0, 1)),
                    16'($urandom));
        sent++;
      end else begin
        centre = int'($urandom_range(0, 40000)) - 20000;
        r = $urandom_range(0, 99);
        if (r < 30)      amp = $urandom_range(0, 100);
        else if (r < 80) amp = $urandom_range(100, 4000);
        else             amp = $urandom_range(4000, 20000);
        half      = $urandom_range(2, 30);
        jitter    = $urandom_range(0, 60);
        burst_len = $urandom_range(10, 60);
        pos       = $urandom_range(0, 2 * half - 1);
        for (k = 0; k < burst_len && sent < count; k++) begin
          tri_pos = (pos < half) ? pos : 2 * half - pos;
          val = centre - amp + (2 * amp * tri_pos) / half
                + int'($urandom_range(0, 2 * jitter)) - jitter;
          pos = (pos + 1) % (2 * half);
          sv = ($urandom_range(0, 9) != 0);
          span_w = 2 * amp + int'($urandom_range(0, 2 * jitter));
          if (span_w > 65535) span_w = 65535;
          sp = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(span_w);
          // time since the last half cycle: mostly inside the quiet limit
          if ($urandom_range(0, 19) == 0) ofs = $urandom;
          else ofs = $urandom_range(0, (quiet_limit < 2000) ? quiet_limit : 2000);
          send_sample(clamp_sample(val), last_half_ms + ofs, sv, sp);
          sent++;
        end
      end
    end
  endtask

  // extremes of every input field with the reset register values
  task automatic test_extremes();
    send_sample(0, 32'h0000_0000, 1'b0, 16'h0000);
    send_sample(32767, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_sample(-32768, 32'hAAAA_5555, 1'b1, 16'h0000);
    send_sample(32767, 32'h5555_AAAA, 1'b0, 16'hAAAA);
    send_sample(-32768, 32'h0000_0001, 1'b1, 16'h5555);
    send_sample(-1, 32'h8000_0000, 1'b1, 16'h8000);
    send_sample(1, 32'h7FFF_FFFF, 1'b0, 16'h7FFF);
  endtask

  // quiet limit boundary, wrap of the millisecond counter and a zero limit
  task automatic test_timeout();
    drain_results();
    write_register(ahhcd_pkg::REG_QUIET_LIMIT_MS, 1000);
    send_sample(100, last_half_ms + 1000, 1'b0, 16'd0);
    send_sample(200, last_half_ms + 1001, 1'b0, 16'd0);
    send_sample(300, last_half_ms - 1, 1'b0, 16'd0);
    send_sample(400, last_half_ms + 5, 1'b0, 16'd0);
    drain_results();
    write_register(ahhcd_pkg::REG_QUIET_LIMIT_MS, 0);
    send_sample(-500, last_half_ms, 1'b0, 16'd0);
    send_sample(-600, last_half_ms + 1, 1'b0, 16'd0);
    drain_results();
    write_register(ahhcd_pkg::REG_QUIET_LIMIT_MS, 32'hFFFF_FFFF);
  endtask

  // noise drop: both conditions at their boundaries, span flag off, no fraction
  task automatic test_noise_drop();
    drain_results();
    write_register(ahhcd_pkg::REG_NOISE_AMPLITUDE, 1000);
    write_register(ahhcd_pkg::REG_RESET_FRACTION_Q8, 256);
    write_register(ahhcd_pkg::REG_NOISE_DROP_MIN, 100);
    send_sample(10, last_half_ms, 1'b1, 16'd899);
    send_sample(20, last_half_ms, 1'b1, 16'd900);
    send_sample(30, last_half_ms, 1'b0, 16'd899);
    send_sample(40, last_half_ms, 1'b1, 16'd1000);
    drain_results();
    write_register(ahhcd_pkg::REG_RESET_FRACTION_Q8, 0);
    send_sample(50, last_half_ms, 1'b1, 16'd0);
    drain_results();
    write_register(ahhcd_pkg::REG_NOISE_AMPLITUDE, 4095);
    write_register(ahhcd_pkg::REG_RESET_FRACTION_Q8, 256);
    write_register(ahhcd_pkg::REG_NOISE_DROP_MIN, 0);
    send_sample(60, last_half_ms, 1'b1, 16'd0);
    drain_results();
    write_register(ahhcd_pkg::REG_NOISE_AMPLITUDE, 0);
    write_register(ahhcd_pkg::REG_RESET_FRACTION_Q8, 0);
  endtask

  // huge margins, so the wake threshold saturates at both ends
  task automatic test_margin_saturation();
    drain_results();
    write_register(ahhcd_pkg::REG_NOISE_AMPLITUDE, 4095);
    write_register(ahhcd_pkg::REG_NOISE_MARGIN_Q8, 1023);
    write_register(ahhcd_pkg::REG_STATIC_MARGIN, 4095);
    write_register(ahhcd_pkg::REG_SPAN_MARGIN_Q8, 256);
    write_register(ahhcd_pkg::REG_CHANGE_THRESHOLD, 4095);
    send_sample(32767, last_half_ms, 1'b1, 16'hFFFF);
    send_sample(-32768, last_half_ms, 1'b1, 16'hFFFF);
    send_sample(32767, last_half_ms, 1'b0, 16'hFFFF);
    send_sample(-32768, last_half_ms, 1'b0, 16'h0000);
    drain_results();
    write_register(ahhcd_pkg::REG_SPAN_MARGIN_Q8, 511);
    send_sample(32767, last_half_ms, 1'b1, 16'hFFFF);
    send_sample(-32768, last_half_ms, 1'b1, 16'hFFFF);
  endtask

  // one random phase per register setting, one of them without any idling
  task automatic test_random_settings();
    load_setting(SET_DEFAULT);
    run_waveform(300);
    load_setting(SET_MODERATE);
    run_waveform(300);
    load_setting(SET_WIDEST);
    idling = 1'b0;
    run_waveform(300);
    idling = 1'b1;
    load_setting(SET_ZERO);
    run_waveform(300);
    load_setting(SET_SCRAMBLED);
    run_waveform(300);
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_result_stall();
    load_setting(SET_MODERATE);
    idling = 1'b0;
    hold_left = 300;
    run_waveform(60);
    idling = 1'b1;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // result sink: random stalls plus the long hold-off when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  // every accepted result word against the oldest prediction
  always @(posedge clk) begin
    detector_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", int'(want.status), int'(out_ch.status));
        compare_field("half_cycle", int'(want.half_cycle), int'(out_ch.half_cycle));
        compare_field("value_changed", int'(want.value_changed), int'(out_ch.value_changed));
        compare_field("threshold_set", int'(want.threshold_set), int'(out_ch.threshold_set));
        compare_field("wake_threshold", int'(want.wake_threshold),
                      int'(out_ch.wake_threshold));
        compare_field("min_seen", int'(want.min_seen), int'(out_ch.min_seen));
        compare_field("max_seen", int'(want.max_seen), int'(out_ch.max_seen));
      end
    end
  end

  initial begin
    // everything known from time zero
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.sample     = '0;
    in_ch.now_ms     = '0;
    in_ch.span_valid = 1'b0;
    in_ch.span       = '0;
    out_ch.ready     = 1'b0;
    // register values after reset
    noise_level      = '0;
    noise_gain_q8    = '0;
    fixed_margin     = '0;
    span_gain_q8     = '0;
    drop_fraction_q8 = '0;
    drop_floor       = '0;
    quiet_limit      = 32'hFFFF_FFFF;
    step_threshold   = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_timeout();
    test_noise_drop();
    test_margin_saturation();
    test_random_settings();
    test_result_stall();

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("adaptive_hysteresis_half_cycle_detector_unit_test passed");
    end else begin
      $display("adaptive_hysteresis_half_cycle_detector_unit_test failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    #12_000_000;
    $display("adaptive_hysteresis_half_cycle_detector_unit_test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/ahhcd_pkg.sv
design/ahhcd_in_if.sv
design/ahhcd_out_if.sv
design/adaptive_hysteresis_half_cycle_detector_unit.sv
test/adaptive_hysteresis_half_cycle_detector_unit_test.sv
